/* src/mscc_pkg.sv */
package mscc_pkg;
    localparam int MEM_WORDS = 64;
    localparam int MEM_AW = $clog2(MEM_WORDS);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0A;
    localparam logic [5:0] OP_SLTIU = 6'h0B;
    localparam logic [5:0] OP_ANDI  = 6'h0C;
    localparam logic [5:0] OP_ORI   = 6'h0D;
    localparam logic [5:0] OP_XORI  = 6'h0E;
    localparam logic [5:0] OP_LUI   = 6'h0F;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;
    localparam logic [5:0] OP_HALT  = 6'h3F;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_SLLV = 6'h04;
    localparam logic [5:0] FN_SRLV = 6'h06;
    localparam logic [5:0] FN_SRAV = 6'h07;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2A;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    typedef enum logic [2:0] {
        FLT_NONE    = 3'd0,
        FLT_HALT    = 3'd1,
        FLT_PC      = 3'd2,
        FLT_OVF     = 3'd3,
        FLT_DADDR   = 3'd4
    } t_fault;

    // execute stage: fetch issues the instruction read, exec decodes,
    // load waits for the data word of lw
    typedef enum logic [1:0] {
        ST_FETCH,
        ST_EXEC,
        ST_LOAD
    } t_bstate;

    // classified item from the front part
    typedef struct packed {
        logic        is_step;
        logic [5:0]  addr;
        logic [31:0] data;
    } t_item;

    typedef struct packed {
        logic [31:0] pc_after;
        logic        halted;
        logic [2:0]  fault;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
    } t_result;
endpackage

/* src/mips_subset_cpu_core_unit.sv */
// Word-addressed MIPS integer-subset core with a 64-word unified memory.
// Items enter on the s_axis side: tuser bit 0 is action (0 load a memory
// word, 1 execute one instruction). A two-entry queue parts the front from
// the execute stage, and an output register parts execution from m_axis.
// The memory is read through a registered port, so the execute stage ends a
// load item, a halted step or a PC-out-of-range step in its fetch state, an
// instruction after fetch and execute, and lw after fetch, execute and data
// read. Each item yields one result.
// Write start_pc through the cfg channel only while idle; it also reloads
// the program counter. Faults halt the core until reset.
module mips_subset_cpu_core_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,       // [5:0] start_pc
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,     // [5:0] load_addr, [37:6] load_data
    input  logic        s_axis_tuser,     // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata      // [31:0] pc_after, [32] halted,
                                          // [35:33] fault, [36] reg_written,
                                          // [41:37] reg_index, [73:42] reg_value
);
    import mscc_pkg::*;

    t_item   w_in, w_q;
    t_result w_res;
    logic    w_qv, w_qr;

    assign o_cfg_ready = 1'b1;
    assign w_in.is_step = s_axis_tuser;
    assign w_in.addr    = s_axis_tdata[5:0];
    assign w_in.data    = s_axis_tdata[37:6];

    mscc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_item(w_q)
    );

    mscc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_valid), .i_cfg_pc(i_cfg_data[5:0]),
        .i_valid(w_qv), .o_ready(w_qr), .i_item(w_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {6'h0, w_res.reg_value, w_res.reg_index, w_res.reg_written,
                           w_res.fault, w_res.halted, w_res.pc_after};
endmodule

/* src/mscc_front.sv */
module mscc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mscc_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output mscc_pkg::t_item o_item
);
    import mscc_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);

    t_item          r_q [QUEUE_DEPTH];
    logic [QW-1:0]  r_wp, r_rp;
    logic [QW:0]    r_cnt;
    logic           w_push, w_pop;

    assign o_ready = (r_cnt != QUEUE_DEPTH[QW:0]);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{QW{1'b0}}, w_push} - {{QW{1'b0}}, w_pop};
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QUEUE_DEPTH[QW:0]) else $error("queue overfilled");
    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == QUEUE_DEPTH[QW:0]) |-> !w_push) else $error("push when full");
    a_empty_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !w_pop) else $error("pop when empty");
endmodule

/* src/mscc_back.sv */
module mscc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [5:0]        i_cfg_pc,
    input  logic              i_valid,
    output logic              o_ready,
    input  mscc_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output mscc_pkg::t_result o_res
);
    import mscc_pkg::*;

    logic [31:0] r_mem [MEM_WORDS];
    logic [31:0] r_gpr [32];
    logic [31:0] r_pc;
    logic        r_stop;
    logic        r_ov;
    logic [31:0] r_rd;
    logic [31:0] r_ir;
    t_bstate     r_st, n_st;
    t_result     r_res;

    logic              w_free, w_done, w_rd_en;
    logic [MEM_AW-1:0] w_rd_addr;
    logic [31:0] ir, a, b, simm, zimm, nxt, r, n_pc, wval, ea;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh, widx;
    logic        wr, memwr, n_stop, fetch, need_ld;
    t_fault      flt;

    assign w_free  = !r_ov || i_ready;
    assign o_ready = w_done;
    assign o_valid = r_ov;
    assign o_res   = r_res;

    always_comb begin
        fetch = i_item.is_step && !r_stop && (r_pc < MEM_WORDS);
        ir   = (r_st == ST_LOAD) ? r_ir : r_rd;
        op   = ir[31:26];
        rs   = ir[25:21];
        rt   = ir[20:16];
        rd   = ir[15:11];
        sh   = ir[10:6];
        fn   = ir[5:0];
        zimm = {16'h0, ir[15:0]};
        simm = {{16{ir[15]}}, ir[15:0]};
        a    = r_gpr[rs];
        b    = r_gpr[rt];
        nxt  = r_pc + 32'd1;
        ea   = a + simm;
        r    = '0;
        n_pc = r_pc;
        wr   = 1'b0;
        widx = '0;
        wval = '0;
        memwr = 1'b0;
        need_ld = 1'b0;
        flt  = FLT_NONE;
        if (i_item.is_step && !r_stop) begin
            if (r_pc >= MEM_WORDS) begin
                flt = FLT_PC;
            end else if (r_st != ST_FETCH) begin
                n_pc = nxt;
                if (op == OP_HALT) begin
                    flt = FLT_HALT;
                end else if (op == OP_RTYPE) begin
                    wr = 1'b1;
                    widx = rd;
                    case (fn)
                        FN_SLL:  wval = b << sh;
                        FN_SRL:  wval = b >> sh;
                        FN_SRA:  wval = $unsigned($signed(b) >>> sh);
                        FN_SLLV: wval = b << a[4:0];
                        FN_SRLV: wval = b >> a[4:0];
                        FN_SRAV: wval = $unsigned($signed(b) >>> a[4:0]);
                        FN_JR: begin
                            wr = 1'b0;
                            n_pc = a;
                        end
                        FN_ADD: begin
                            r = a + b;
                            if (((a ^ r) & (b ^ r)) >> 31 != 0) begin
                                flt = FLT_OVF;
                                wr = 1'b0;
                            end else wval = r;
                        end
                        FN_ADDU: wval = a + b;
                        FN_SUB: begin
                            r = a - b;
                            if (((a ^ b) & (a ^ r)) >> 31 != 0) begin
                                flt = FLT_OVF;
                                wr = 1'b0;
                            end else wval = r;
                        end
                        FN_SUBU: wval = a - b;
                        FN_AND:  wval = a & b;
                        FN_OR:   wval = a | b;
                        FN_XOR:  wval = a ^ b;
                        FN_NOR:  wval = ~(a | b);
                        FN_SLT:  wval = {31'h0, $signed(a) < $signed(b)};
                        FN_SLTU: wval = {31'h0, a < b};
                        default: wr = 1'b0;
                    endcase
                end else if (op == OP_J || op == OP_JAL) begin
                    if (op == OP_JAL) begin
                        wr = 1'b1;
                        widx = 5'd31;
                        wval = nxt;
                    end
                    n_pc = {nxt[31:26], ir[25:0]};
                end else begin
                    widx = rt;
                    case (op)
                        OP_ADDI: begin
                            r = a + simm;
                            if (((a ^ r) & (simm ^ r)) >> 31 != 0) flt = FLT_OVF;
                            else begin
                                wr = 1'b1;
                                wval = r;
                            end
                        end
                        OP_ADDIU: begin wr = 1'b1; wval = a + simm; end
                        OP_SLTI: begin
                            wr = 1'b1;
                            wval = {31'h0, $signed(a) < $signed(simm)};
                        end
                        OP_SLTIU: begin wr = 1'b1; wval = {31'h0, a < simm}; end
                        OP_ANDI: begin wr = 1'b1; wval = a & zimm; end
                        OP_ORI:  begin wr = 1'b1; wval = a | zimm; end
                        OP_XORI: begin wr = 1'b1; wval = a ^ zimm; end
                        OP_LUI:  begin wr = 1'b1; wval = {ir[15:0], 16'h0}; end
                        OP_LW: begin
                            if (ea >= MEM_WORDS) flt = FLT_DADDR;
                            else begin
                                // data word is registered from the read and taken in the load state
                                wr = 1'b1;
                                wval = r_rd;
                                need_ld = (r_st == ST_EXEC);
                            end
                        end
                        OP_SW: begin
                            if (ea >= MEM_WORDS) flt = FLT_DADDR;
                            else memwr = 1'b1;
                        end
                        OP_BEQ: if (a == b) n_pc = nxt + simm;
                        OP_BNE: if (a != b) n_pc = nxt + simm;
                        default: wr = 1'b0;
                    endcase
                end
                if (widx == 5'd0) wr = 1'b0;
            end
        end
        if (!wr) begin
            widx = '0;
            wval = '0;
        end
        n_stop = r_stop || (flt != FLT_NONE);

        unique case (r_st)
            ST_FETCH: w_done = i_valid && !fetch && w_free;
            ST_EXEC:  w_done = !need_ld && w_free;
            ST_LOAD:  w_done = w_free;
            default:  w_done = 1'b0;
        endcase
        w_rd_en   = ((r_st == ST_FETCH) && i_valid && fetch) || need_ld;
        w_rd_addr = need_ld ? ea[MEM_AW-1:0] : r_pc[MEM_AW-1:0];
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_FETCH: if (i_valid && fetch) n_st = ST_EXEC;
            ST_EXEC: begin
                if (need_ld) n_st = ST_LOAD;
                else if (w_free) n_st = ST_FETCH;
            end
            ST_LOAD: if (w_free) n_st = ST_FETCH;
            default: n_st = ST_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            if (!i_item.is_step && (i_item.addr < MEM_WORDS)) begin
                r_mem[i_item.addr[MEM_AW-1:0]] <= i_item.data;
            end else if (memwr) begin
                r_mem[ea[MEM_AW-1:0]] <= b;
            end
        end
        if (w_rd_en) r_rd <= r_mem[w_rd_addr];
        if (need_ld) r_ir <= r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_res.pc_after    <= n_pc;
            r_res.halted      <= n_stop;
            r_res.fault       <= flt;
            r_res.reg_written <= wr;
            r_res.reg_index   <= widx;
            r_res.reg_value   <= wval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 32; k++) r_gpr[k] <= '0;
            r_pc   <= '0;
            r_stop <= 1'b0;
            r_ov   <= 1'b0;
            r_st   <= ST_FETCH;
        end else begin
            if (i_cfg_we) begin
                r_pc <= {26'h0, i_cfg_pc};
            end else if (w_done && i_item.is_step) begin
                r_pc   <= n_pc;
                r_stop <= n_stop;
                if (wr) r_gpr[widx] <= wval;
            end
            if (w_done) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            r_st <= n_st;
        end
    end

    a_zero_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gpr[0] == '0) else $error("register zero changed");
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop |=> r_stop) else $error("stop cleared");
    a_fault_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.fault != FLT_NONE) |-> o_res.halted)
        else $error("fault without halt");
    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_FETCH) |-> i_valid) else $error("item lost mid-instruction");
endmodule

/* bench/mscc_checker.sv */
`timescale 1ns / 1ps

module mscc_checker
    import mscc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [79:0] i_m_tdata,
    output int          o_errors,
    output int          o_pending
);

    logic [31:0] gpr [32];
    logic [31:0] mem [MEM_WORDS];
    logic [31:0] pc;
    logic        stopped;
    t_result     expected_q[$];
    int          err_cnt = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (err_cnt < 20)
            $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // one instruction or memory load; updates the core state copy
    function automatic t_result execute(input logic act, input logic [5:0] la,
                                        input logic [31:0] ld);
        t_result     res;
        logic [31:0] ir, a, b, r, simm, imm, nxt, wval;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sh, widx;
        logic        wr;
        t_fault      flt;
        flt = FLT_NONE; wr = 1'b0; widx = '0; wval = '0;
        if (!act) begin
            mem[la] = ld;
        end else if (!stopped) begin
            if (pc >= MEM_WORDS) begin
                flt = FLT_PC;
            end else begin
                ir = mem[pc[MEM_AW-1:0]];
                op = ir[31:26]; rs = ir[25:21]; rt = ir[20:16];
                rd = ir[15:11]; sh = ir[10:6]; fn = ir[5:0];
                imm = {16'h0, ir[15:0]};
                simm = {{16{ir[15]}}, ir[15:0]};
                a = gpr[rs]; b = gpr[rt];
                nxt = pc + 1;
                pc = nxt;
                if (op == OP_HALT) begin
                    flt = FLT_HALT;
                end else if (op == OP_RTYPE) begin
                    wr = 1'b1; widx = rd;
                    case (fn)
                        FN_SLL:  wval = b << sh;
                        FN_SRL:  wval = b >> sh;
                        FN_SRA:  wval = $signed(b) >>> sh;
                        FN_SLLV: wval = b << a[4:0];
                        FN_SRLV: wval = b >> a[4:0];
                        FN_SRAV: wval = $signed(b) >>> a[4:0];
                        FN_JR: begin
                            wr = 1'b0; pc = a;
                        end
                        FN_ADD: begin
                            r = a + b;
                            if (((a ^ r) & (b ^ r)) >> 31) begin
                                flt = FLT_OVF; wr = 1'b0;
                            end else wval = r;
                        end
                        FN_ADDU: wval = a + b;
                        FN_SUB: begin
                            r = a - b;
                            if (((a ^ b) & (a ^ r)) >> 31) begin
                                flt = FLT_OVF; wr = 1'b0;
                            end else wval = r;
                        end
                        FN_SUBU: wval = a - b;
                        FN_AND:  wval = a & b;
                        FN_OR:   wval = a | b;
                        FN_XOR:  wval = a ^ b;
                        FN_NOR:  wval = ~(a | b);
                        FN_SLT:  wval = {31'h0, $signed(a) < $signed(b)};
                        FN_SLTU: wval = {31'h0, a < b};
                        default: wr = 1'b0;
                    endcase
                end else if (op == OP_J || op == OP_JAL) begin
                    if (op == OP_JAL) begin
                        wr = 1'b1; widx = 5'd31; wval = nxt;
                    end
                    pc = {nxt[31:26], ir[25:0]};
                end else begin
                    wr = 1'b1; widx = rt;
                    case (op)
                        OP_ADDI: begin
                            r = a + simm;
                            if (((a ^ r) & (simm ^ r)) >> 31) begin
                                flt = FLT_OVF; wr = 1'b0;
                            end else wval = r;
                        end
                        OP_ADDIU: wval = a + simm;
                        OP_SLTI:  wval = {31'h0, $signed(a) < $signed(simm)};
                        OP_SLTIU: wval = {31'h0, a < simm};
                        OP_ANDI:  wval = a & imm;
                        OP_ORI:   wval = a | imm;
                        OP_XORI:  wval = a ^ imm;
                        OP_LUI:   wval = {ir[15:0], 16'h0};
                        OP_LW: begin
                            r = a + simm;
                            if (r >= MEM_WORDS) begin
                                flt = FLT_DADDR; wr = 1'b0;
                            end else wval = mem[r[MEM_AW-1:0]];
                        end
                        OP_SW: begin
                            wr = 1'b0;
                            r = a + simm;
                            if (r >= MEM_WORDS) flt = FLT_DADDR;
                            else mem[r[MEM_AW-1:0]] = b;
                        end
                        OP_BEQ: begin
                            wr = 1'b0;
                            if (a == b) pc = nxt + simm;
                        end
                        OP_BNE: begin
                            wr = 1'b0;
                            if (a != b) pc = nxt + simm;
                        end
                        default: wr = 1'b0;
                    endcase
                end
                if (wr && widx == 5'd0) wr = 1'b0;
                if (wr) gpr[widx] = wval;
            end
            if (flt != FLT_NONE) stopped = 1'b1;
        end
        if (!wr) begin
            widx = '0; wval = '0;
        end
        res.pc_after = pc;
        res.halted = stopped;
        res.fault = flt;
        res.reg_written = wr;
        res.reg_index = widx;
        res.reg_value = wval;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            foreach (gpr[k]) gpr[k] = '0;
            foreach (mem[k]) mem[k] = '0;
            pc = '0;
            stopped = 1'b0;
            expected_q.delete();
        end else begin
            // drain first: the output side sees results of earlier items only
            if (i_m_tvalid && i_m_tready) begin
                got.pc_after    = i_m_tdata[31:0];
                got.halted      = i_m_tdata[32];
                got.fault       = i_m_tdata[35:33];
                got.reg_written = i_m_tdata[36];
                got.reg_index   = i_m_tdata[41:37];
                got.reg_value   = i_m_tdata[73:42];
                if (expected_q.size() == 0) begin
                    report("unexpected result", got.pc_after, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.pc_after !== want.pc_after)
                        report("pc_after", got.pc_after, want.pc_after);
                    if (got.halted !== want.halted)
                        report("halted", 32'(got.halted), 32'(want.halted));
                    if (got.fault !== want.fault)
                        report("fault", 32'(got.fault), 32'(want.fault));
                    if (got.reg_written !== want.reg_written)
                        report("reg_written", 32'(got.reg_written), 32'(want.reg_written));
                    if (got.reg_index !== want.reg_index)
                        report("reg_index", 32'(got.reg_index), 32'(want.reg_index));
                    if (got.reg_value !== want.reg_value)
                        report("reg_value", got.reg_value, want.reg_value);
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                pc = {26'h0, i_cfg_data[5:0]};
            if (i_s_tvalid && i_s_tready)
                expected_q.push_back(execute(i_s_tuser, i_s_tdata[5:0], i_s_tdata[37:6]));
        end
        o_pending <= expected_q.size();
    end

    assign o_errors = err_cnt;

endmodule

/* bench/tb_mips_subset_cpu_core_unit.sv */
`timescale 1ns / 1ps

module tb_mips_subset_cpu_core_unit;
    import mscc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;       // [5:0] start_pc
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;     // [5:0] load_addr, [37:6] load_data
    logic        s_axis_tuser;     // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;     // pc_after, halted, fault, reg_written, reg_index, reg_value

    int errors, pending, cycles;
    int idle_pct, stall_pct;
    logic hold_go;
    int   hold_left;

    // program counter as the stimulus sees it; only instructions whose
    // control flow is known ahead are issued, so it leaves the memory only in the closing fault case
    int          cur_pc;
    logic        link_known;
    logic [31:0] link_val;

    mips_subset_cpu_core_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    mscc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
        end else if (hold_go && hold_left == 0) begin
            hold_left <= 300;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic [31:0] enc_r(input logic [4:0] rs, rt, rd, sh,
                                          input logic [5:0] fn);
        return {OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs, rt,
                                          input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] enc_j(input logic [5:0] op, input int tgt);
        return {op, 26'(tgt)};
    endfunction

    // offer one item and hold it until taken, then maybe go idle
    task automatic send(input logic act, input logic [5:0] la, input logic [31:0] ld);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {2'b00, ld, la};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 40'({$urandom, $urandom});
            @(posedge i_clk);
        end
    endtask

    // place the word at the current pc, then execute it
    task automatic run_word(input logic [31:0] word, input int nxt);
        send(1'b0, 6'(cur_pc), word);
        send(1'b1, 6'($urandom), $urandom);
        cur_pc = nxt;
    endtask

    task automatic write_start(input logic [5:0] spc);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= {2'($urandom), spc};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_pc = spc;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [4:0] dst_reg();
        return 5'($urandom_range(0, 30));
    endfunction

    // one instruction whose effect on control flow and faults is known
    task automatic random_instr();
        logic [31:0] w;
        logic [5:0]  fn;
        int          nxt, tgt, kind;
        logic [5:0]  free_fn [15];
        logic [5:0]  free_op [7];
        logic [5:0]  odd_op [6];
        free_fn = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_ADDU, FN_SUBU,
                    FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU, 6'h3A};
        free_op = '{OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI};
        odd_op  = '{6'h01, 6'h06, 6'h07, 6'h10, 6'h20, 6'h3E};
        nxt = cur_pc + 1;
        tgt = $urandom_range(0, 59);
        kind = $urandom_range(0, 13);
        if (cur_pc >= 60) kind = 7;   // jump back before running off the end
        case (kind)
            0, 1, 2: begin
                fn = free_fn[$urandom_range(0, 14)];
                w = enc_r(5'($urandom), 5'($urandom), dst_reg(), 5'($urandom), fn);
            end
            3: begin
                // add with a zero operand and sub of equal operands cannot overflow
                case ($urandom_range(0, 2))
                    0: w = enc_r(5'($urandom), 5'd0, dst_reg(), 5'($urandom), FN_ADD);
                    1: w = enc_r(5'd0, 5'($urandom), dst_reg(), 5'($urandom), FN_ADD);
                    default: begin
                        fn = 6'($urandom);
                        w = enc_r(fn[4:0], fn[4:0], dst_reg(), 5'($urandom), FN_SUB);
                    end
                endcase
            end
            4, 5: w = enc_i(free_op[$urandom_range(0, 6)], 5'($urandom), dst_reg(),
                            16'($urandom));
            6: w = enc_i(OP_ADDI, 5'd0, dst_reg(), 16'($urandom));
            7: begin
                w = enc_j(OP_J, tgt);
                nxt = tgt;
            end
            8: begin
                w = enc_j(OP_JAL, tgt);
                link_known = 1'b1;
                link_val = cur_pc + 1;
                nxt = tgt;
            end
            9: begin
                if (link_known) begin
                    w = enc_r(5'd31, 5'($urandom), 5'($urandom), 5'($urandom), FN_JR);
                    nxt = link_val;
                end else begin
                    w = enc_i(odd_op[$urandom_range(0, 5)], 5'($urandom), 5'($urandom),
                              16'($urandom));
                end
            end
            10: begin
                // lw never lands in the link register
                if ($urandom_range(0, 1))
                    w = enc_i(OP_LW, 5'd0, dst_reg(),
                              16'($urandom_range(0, MEM_WORDS - 1)));
                else
                    w = enc_i(OP_SW, 5'd0, 5'($urandom),
                              16'($urandom_range(0, MEM_WORDS - 1)));
            end
            11: begin
                // a zero offset lands on the next word whether taken or not
                w = enc_i($urandom_range(0, 1) ? OP_BEQ : OP_BNE, 5'($urandom),
                          5'($urandom), 16'h0);
            end
            12: begin
                if ($urandom_range(0, 1)) begin
                    w = enc_i(OP_BEQ, 5'd0, 5'd0, 16'(tgt - nxt));
                    nxt = tgt;
                end else begin
                    w = enc_i(OP_BNE, 5'd0, 5'd0, 16'($urandom));
                end
            end
            default: w = enc_i(odd_op[$urandom_range(0, 5)], 5'($urandom), 5'($urandom),
                               16'($urandom));
        endcase
        run_word(w, nxt);
    endtask

    task automatic random_phase(input int steps);
        repeat (steps) begin
            if ($urandom_range(0, 9) == 0)
                send(1'b0, 6'($urandom), $urandom);   // stray memory write
            random_instr();
        end
    endtask

    initial begin
        int n;
        idle_pct = 0;
        stall_pct = 0;
        hold_go = 1'b0;
        link_known = 1'b0;
        link_val = '0;
        cur_pc = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_start(6'd0);
        // fill the whole memory so no fetch or lw sees an unwritten word
        for (n = 0; n < MEM_WORDS; n++)
            send(1'b0, 6'(n), $urandom);

        // directed: extreme values, sign handling, register zero, calls
        run_word(enc_i(OP_LUI, 5'd0, 5'd1, 16'hFFFF), cur_pc + 1);
        run_word(enc_i(OP_ORI, 5'd1, 5'd1, 16'hFFFF), cur_pc + 1);
        run_word(enc_r(5'd0, 5'd1, 5'd2, 5'd31, FN_SRA), cur_pc + 1);
        run_word(enc_r(5'd0, 5'd1, 5'd3, 5'd31, FN_SRL), cur_pc + 1);
        run_word(enc_i(OP_ADDIU, 5'd0, 5'd4, 16'h8000), cur_pc + 1);
        run_word(enc_i(OP_SLTIU, 5'd4, 5'd5, 16'hFFFF), cur_pc + 1);
        run_word(enc_i(OP_SLTI, 5'd4, 5'd6, 16'h0001), cur_pc + 1);
        run_word(enc_i(OP_ANDI, 5'd1, 5'd7, 16'h8001), cur_pc + 1);
        run_word(enc_i(OP_LUI, 5'd0, 5'd8, 16'h8000), cur_pc + 1);
        run_word(enc_r(5'd8, 5'd8, 5'd9, 5'd0, FN_SUB), cur_pc + 1);
        run_word(enc_r(5'd8, 5'd1, 5'd10, 5'd0, FN_SLT), cur_pc + 1);
        run_word(enc_r(5'd8, 5'd1, 5'd11, 5'd0, FN_SLTU), cur_pc + 1);
        run_word(enc_r(5'd1, 5'd1, 5'd0, 5'd0, FN_ADDU), cur_pc + 1);
        run_word(enc_r(5'd1, 5'd8, 5'd12, 5'd0, FN_SRAV), cur_pc + 1);
        run_word(enc_i(OP_SW, 5'd0, 5'd1, 16'd63), cur_pc + 1);
        run_word(enc_i(OP_LW, 5'd0, 5'd13, 16'd63), cur_pc + 1);
        run_word(enc_i(OP_ADDI, 5'd0, 5'd14, 16'h7FFF), cur_pc + 1);
        link_known = 1'b1;
        link_val = cur_pc + 1;
        run_word(enc_j(OP_JAL, 40), 40);
        run_word(enc_r(5'd31, 5'd0, 5'd0, 5'd0, FN_JR), link_val);
        run_word(enc_i(OP_BEQ, 5'd0, 5'd0, 16'hFFFE), cur_pc - 1);
        run_word(enc_i(OP_BNE, 5'd0, 5'd0, 16'h0005), cur_pc + 1);
        run_word(enc_i(6'h01, 5'd31, 5'd31, 16'hFFFF), cur_pc + 1);

        // free flow on both sides, with a long output hold-off
        random_phase(60);
        s_axis_tvalid <= 1'b0;
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        random_phase(190);

        // pause until every result is back, then move the start address
        drain();
        link_known = 1'b0;
        write_start(6'd63);
        idle_pct = 80;
        random_phase(250);

        drain();
        link_known = 1'b0;
        write_start(6'($urandom_range(1, 62)));
        idle_pct = 0;
        stall_pct = 80;
        random_phase(250);

        drain();
        link_known = 1'b0;
        write_start(6'd1);
        idle_pct = 12;
        stall_pct = 12;
        random_phase(250);

        // finish with one fault, then show the core stays stopped
        if (cur_pc >= 55) run_word(enc_j(OP_J, 0), 0);
        case ($urandom_range(1, 4))
            1: run_word({OP_HALT, 26'($urandom)}, cur_pc + 1);
            2: begin
                run_word(enc_j(OP_J, MEM_WORDS), MEM_WORDS);
                send(1'b1, 6'($urandom), $urandom);
            end
            3: begin
                run_word(enc_i(OP_LUI, 5'd0, 5'd1, 16'h7FFF), cur_pc + 1);
                run_word(enc_i(OP_ORI, 5'd1, 5'd1, 16'hFFFF), cur_pc + 1);
                if ($urandom_range(0, 1))
                    run_word(enc_i(OP_ADDI, 5'd1, 5'd2, 16'h0001), cur_pc + 1);
                else
                    run_word(enc_r(5'd1, 5'd1, 5'd2, 5'd0, FN_ADD), cur_pc + 1);
            end
            default: run_word(enc_i($urandom_range(0, 1) ? OP_LW : OP_SW, 5'd0, 5'd3,
                                    $urandom_range(0, 1) ? 16'd64 : 16'hFFFF), cur_pc + 1);
        endcase
        repeat (6) begin
            send(1'b1, 6'($urandom), $urandom);
            send(1'b0, 6'($urandom), $urandom);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
